FILE: src/dpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpw_pkg
// Shared types and constants of the depth pixel to world point unit.
// ----------------------------------------------------------------------------
package dpw_pkg;

  localparam int DPW_MAX_FRAMES = 1024;
  localparam int POSE_WORDS     = 12;
  localparam int FRAME_W        = 10;
  localparam int ENTRY_W        = 4;
  localparam int WORD_W         = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;

  localparam logic [ENTRY_W-1:0] ENTRY_LAST = ENTRY_W'(POSE_WORDS - 1);

  // function codes of an input word
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_POINT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_INV_FOCALX = 3'd2,
    CFG_INV_FOCALY = 3'd3,
    CFG_POSE_COUNT = 3'd4
  } dpw_cfg_e;

  localparam logic [11:0] CENTER_X_RST   = 12'd639;
  localparam logic [11:0] CENTER_Y_RST   = 12'd479;
  localparam logic [23:0] INV_FOCAL_RST  = 24'd31957;
  localparam logic [10:0] POSE_COUNT_RST = 11'd0;

  typedef struct packed {
    logic [11:0] center_x_twice;
    logic [11:0] center_y_twice;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [10:0] pose_count;
  } dpw_cfg_t;

  // side information that rides along with every word
  typedef struct packed {
    logic               func;
    logic               status;
    logic [FRAME_W-1:0] frame;
    logic [ENTRY_W-1:0] entry;
    logic [WORD_W-1:0]  value;
  } dpw_tag_t;

  typedef logic [POSE_WORDS-1:0][WORD_W-1:0] dpw_pose_t;

endpackage

FILE: src/dpw_pose_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpw_pose_mem
// Pose storage: one bank per matrix element, so a whole pose reads at once.
// ----------------------------------------------------------------------------
module dpw_pose_mem #(
  parameter int MAX_FRAMES = dpw_pkg::DPW_MAX_FRAMES,
  parameter int ADDR_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic                        we_i,
  input  logic [dpw_pkg::ENTRY_W-1:0] bank_i,
  input  logic [ADDR_W-1:0]           addr_i,
  input  logic [dpw_pkg::WORD_W-1:0]  wdata_i,
  output dpw_pkg::dpw_pose_t          rdata_o
);
  import dpw_pkg::*;

  dpw_pose_t rdata_q;

  for (genvar g = 0; g < POSE_WORDS; g++) begin : g_bank
    logic [WORD_W-1:0] mem [MAX_FRAMES];

    always_ff @(posedge clk_i) begin
      if (we_i && (bank_i == ENTRY_W'(g))) begin
        mem[addr_i] <= wdata_i;
      end
      if (adv_i) begin
        rdata_q[g] <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/dpw_back_proj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpw_back_proj
// Pinhole back-projection: depth to z, then sensor x and y, five stages.
// ----------------------------------------------------------------------------
module dpw_back_proj #(
  parameter int MAX_FRAMES = dpw_pkg::DPW_MAX_FRAMES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  dpw_pkg::dpw_cfg_t           cfg_i,
  input  logic                        func_i,
  input  logic [dpw_pkg::FRAME_W-1:0] frame_i,
  input  logic [dpw_pkg::ENTRY_W-1:0] entry_i,
  input  logic [dpw_pkg::WORD_W-1:0]  entry_value_i,
  input  logic [10:0]                 col_i,
  input  logic [10:0]                 row_i,
  input  logic [15:0]                 depth_mm_i,
  output logic                        valid_o,
  output dpw_pkg::dpw_tag_t           tag_o,
  output logic [dpw_pkg::WORD_W-1:0]  x_o,
  output logic [dpw_pkg::WORD_W-1:0]  y_o,
  output logic [dpw_pkg::WORD_W-1:0]  z_o
);
  import dpw_pkg::*;

  localparam int LIM_W = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = (LIM_W > FRAME_W) ? LIM_W : FRAME_W;

  // ceil(2^36 / 125): floor(m / 125) = (m * Z_RECIP) >> 36 for m below 2^29
  localparam logic [29:0] Z_RECIP = 30'd549755814;
  localparam logic [28:0] Z_BIAS  = 29'd62;
  localparam logic [61:0] HALF25  = 62'd16777216;

  function automatic logic [WORD_W-1:0] round_sat25(input logic [61:0] v);
    logic [61:0] t;
    logic [36:0] r;
    t = v + HALF25 - 62'(v[61]);
    r = t[61:25];
    if (!r[36] && (r[35:31] != 5'b00000)) begin
      round_sat25 = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (r[36] && (r[35:31] != 5'b11111)) begin
      round_sat25 = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      round_sat25 = r[31:0];
    end
  endfunction

  // stage 1: captured input
  logic        v1_q;
  dpw_tag_t    tag1_q;
  logic [10:0] col1_q, row1_q;
  logic [15:0] depth1_q;

  // stage 2: z product, pixel offsets
  logic               v2_q;
  dpw_tag_t           tag2_q, tag2_d;
  logic [58:0]        zprod2_q, zprod2_d;
  logic signed [12:0] dx2_q, dx2_d, dy2_q, dy2_d;

  // stage 3: offset times z
  logic               v3_q;
  dpw_tag_t           tag3_q;
  logic [22:0]        z3_q, z3_d;
  logic signed [36:0] dzx3_q, dzx3_d, dzy3_q, dzy3_d;

  // stage 4: times inverse focal length
  logic               v4_q;
  dpw_tag_t           tag4_q;
  logic [22:0]        z4_q;
  logic signed [61:0] px4_q, px4_d, py4_q, py4_d;

  // stage 5: rounded and saturated point
  logic              v5_q;
  dpw_tag_t          tag5_q;
  logic [WORD_W-1:0] x5_q, y5_q, z5_q;

  logic [28:0] zm;
  logic        frame_big;

  always_comb begin
    frame_big = CMP_W'(tag1_q.frame) >= CMP_W'(MAX_FRAMES);
    tag2_d    = tag1_q;
    if (tag1_q.func == FUNC_WRITE) begin
      tag2_d.status = (tag1_q.entry > ENTRY_LAST) || frame_big;
    end else begin
      tag2_d.status = ({1'b0, tag1_q.frame} >= cfg_i.pose_count) || frame_big;
    end
    zm       = {depth1_q, 13'd0} + Z_BIAS;
    zprod2_d = 59'(zm) * 59'(Z_RECIP);
    dx2_d    = $signed({1'b0, col1_q, 1'b0} - {1'b0, cfg_i.center_x_twice});
    dy2_d    = $signed({1'b0, row1_q, 1'b0} - {1'b0, cfg_i.center_y_twice});

    z3_d   = zprod2_q[58:36];
    dzx3_d = dx2_q * $signed({1'b0, z3_d});
    dzy3_d = dy2_q * $signed({1'b0, z3_d});

    px4_d = dzx3_q * $signed({1'b0, cfg_i.inv_focal_x});
    py4_d = dzy3_q * $signed({1'b0, cfg_i.inv_focal_y});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag1_q.func   <= func_i;
      tag1_q.status <= 1'b0;
      tag1_q.frame  <= frame_i;
      tag1_q.entry  <= entry_i;
      tag1_q.value  <= entry_value_i;
      col1_q        <= col_i;
      row1_q        <= row_i;
      depth1_q      <= depth_mm_i;

      tag2_q   <= tag2_d;
      zprod2_q <= zprod2_d;
      dx2_q    <= dx2_d;
      dy2_q    <= dy2_d;

      tag3_q <= tag2_q;
      z3_q   <= z3_d;
      dzx3_q <= dzx3_d;
      dzy3_q <= dzy3_d;

      tag4_q <= tag3_q;
      z4_q   <= z3_q;
      px4_q  <= px4_d;
      py4_q  <= py4_d;

      tag5_q <= tag4_q;
      x5_q   <= round_sat25(px4_q);
      y5_q   <= round_sat25(py4_q);
      z5_q   <= WORD_W'(z4_q);
    end
  end

  assign valid_o = v5_q;
  assign tag_o   = tag5_q;
  assign x_o     = x5_q;
  assign y_o     = y5_q;
  assign z_o     = z5_q;

endmodule

FILE: src/dpw_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpw_transform
// Rigid pose applied to the sensor point: products, rounding, sum, saturate.
// ----------------------------------------------------------------------------
module dpw_transform (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  dpw_pkg::dpw_tag_t          tag_i,
  input  logic [dpw_pkg::WORD_W-1:0] x_i,
  input  logic [dpw_pkg::WORD_W-1:0] y_i,
  input  logic [dpw_pkg::WORD_W-1:0] z_i,
  input  dpw_pkg::dpw_pose_t         pose_i,
  output logic                       valid_o,
  output logic                       status_o,
  output logic [dpw_pkg::WORD_W-1:0] world_x_o,
  output logic [dpw_pkg::WORD_W-1:0] world_y_o,
  output logic [dpw_pkg::WORD_W-1:0] world_z_o
);
  import dpw_pkg::*;

  localparam logic [63:0] HALF16 = 64'd32768;

  typedef logic [2:0][WORD_W-1:0] vec3_t;

  function automatic logic [WORD_W-1:0] sat50(input logic [49:0] s);
    if (!s[49] && (s[48:31] != '0)) begin
      sat50 = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (s[49] && (s[48:31] != '1)) begin
      sat50 = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat50 = s[31:0];
    end
  endfunction

  // stage 1: point and pose
  logic     v1_q;
  dpw_tag_t tag1_q;
  vec3_t    p1_q;

  // stage 2: nine products
  logic                     v2_q;
  dpw_tag_t                 tag2_q;
  logic [2:0][2:0][63:0]    prod2_q, prod2_d;
  vec3_t                    off2_q, off2_d;

  // stage 3: rounded products
  logic                     v3_q;
  dpw_tag_t                 tag3_q;
  logic [2:0][2:0][47:0]    rnd3_q, rnd3_d;
  vec3_t                    off3_q;

  // stage 4: output word
  logic              v4_q;
  logic              status4_q;
  vec3_t             w4_q, w4_d;

  logic [63:0] t;
  logic [49:0] acc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off2_d[i] = pose_i[i*4+3];
      for (int j = 0; j < 3; j++) begin
        prod2_d[i][j] = $signed(pose_i[i*4+j]) * $signed(p1_q[j]);
      end
    end

    t = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t            = prod2_q[i][j] + HALF16 - 64'(prod2_q[i][j][63]);
        rnd3_d[i][j] = t[63:16];
      end
    end

    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc = {{2{rnd3_q[i][0][47]}}, rnd3_q[i][0]}
          + {{2{rnd3_q[i][1][47]}}, rnd3_q[i][1]}
          + {{2{rnd3_q[i][2][47]}}, rnd3_q[i][2]}
          + {{18{off3_q[i][31]}}, off3_q[i]};
      // write words and rejected frames give a zero point
      if ((tag3_q.func == FUNC_WRITE) || tag3_q.status) begin
        w4_d[i] = '0;
      end else begin
        w4_d[i] = sat50(acc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag1_q    <= tag_i;
      p1_q      <= {z_i, y_i, x_i};
      tag2_q    <= tag1_q;
      prod2_q   <= prod2_d;
      off2_q    <= off2_d;
      tag3_q    <= tag2_q;
      rnd3_q    <= rnd3_d;
      off3_q    <= off2_q;
      status4_q <= tag3_q.status;
      w4_q      <= w4_d;
    end
  end

  assign valid_o   = v4_q;
  assign status_o  = status4_q;
  assign world_x_o = w4_q[0];
  assign world_y_o = w4_q[1];
  assign world_z_o = w4_q[2];

endmodule

FILE: src/depth_pixel_to_world_point_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_unit
// Depth pixel back-projection and rigid pose transform to a world point.
// ----------------------------------------------------------------------------
// Input words arrive on a valid/ready channel. A write word (func 0) stores
// one pose element for a frame; a point word (func 1) turns column, row and
// depth into world x, y, z with the pose of its frame. Every word yields one
// result word on the output valid/ready channel, in order.
// The pipeline has nine register stages and takes one word per cycle while
// the receiver does not stall. The pose banks are written and read in the
// same stage, so a write is seen by every later word. When the receiver
// stalls with a result waiting, the whole pipeline holds and in_ready_o
// falls; nothing is dropped or repeated.
// Reset empties the pipeline and loads the default camera registers with a
// pose count of zero; the pose banks are not cleared and must be written
// before a frame is used. Configuration writes take effect at once; the user
// must make them while no word is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_unit #(
  parameter int MAX_FRAMES = dpw_pkg::DPW_MAX_FRAMES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dpw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dpw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [dpw_pkg::FRAME_W-1:0]   frame_i,
  input  logic [dpw_pkg::ENTRY_W-1:0]   entry_i,
  input  logic signed [31:0]            entry_value_i,
  input  logic [10:0]                   col_i,
  input  logic [10:0]                   row_i,
  input  logic [15:0]                   depth_mm_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic signed [31:0]            world_x_o,
  output logic signed [31:0]            world_y_o,
  output logic signed [31:0]            world_z_o
);
  import dpw_pkg::*;

  localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  dpw_cfg_t cfg_q;

  logic              adv;
  logic              bp_valid;
  dpw_tag_t          bp_tag;
  logic [WORD_W-1:0] bp_x, bp_y, bp_z;
  dpw_pose_t         pose;
  logic              mem_we;
  logic              tr_valid;
  logic [WORD_W-1:0] wx, wy, wz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x_twice <= CENTER_X_RST;
      cfg_q.center_y_twice <= CENTER_Y_RST;
      cfg_q.inv_focal_x    <= INV_FOCAL_RST;
      cfg_q.inv_focal_y    <= INV_FOCAL_RST;
      cfg_q.pose_count     <= POSE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X:   cfg_q.center_x_twice <= cfg_data_i[11:0];
        CFG_CENTER_Y:   cfg_q.center_y_twice <= cfg_data_i[11:0];
        CFG_INV_FOCALX: cfg_q.inv_focal_x    <= cfg_data_i;
        CFG_INV_FOCALY: cfg_q.inv_focal_y    <= cfg_data_i;
        CFG_POSE_COUNT: cfg_q.pose_count     <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // one enable for every stage: move unless a result waits untaken
  assign adv        = !tr_valid || out_ready_i;
  assign in_ready_o = adv;

  dpw_back_proj #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_back_proj (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_valid_i),
    .cfg_i        (cfg_q),
    .func_i       (func_i),
    .frame_i      (frame_i),
    .entry_i      (entry_i),
    .entry_value_i(entry_value_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .depth_mm_i   (depth_mm_i),
    .valid_o      (bp_valid),
    .tag_o        (bp_tag),
    .x_o          (bp_x),
    .y_o          (bp_y),
    .z_o          (bp_z)
  );

  assign mem_we = adv && bp_valid && (bp_tag.func == FUNC_WRITE) && !bp_tag.status;

  dpw_pose_mem #(
    .MAX_FRAMES(MAX_FRAMES),
    .ADDR_W    (ADDR_W)
  ) u_pose_mem (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .we_i   (mem_we),
    .bank_i (bp_tag.entry),
    .addr_i (ADDR_W'(bp_tag.frame)),
    .wdata_i(bp_tag.value),
    .rdata_o(pose)
  );

  dpw_transform u_transform (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (bp_valid),
    .tag_i    (bp_tag),
    .x_i      (bp_x),
    .y_i      (bp_y),
    .z_i      (bp_z),
    .pose_i   (pose),
    .valid_o  (tr_valid),
    .status_o (status_o),
    .world_x_o(wx),
    .world_y_o(wy),
    .world_z_o(wz)
  );

  assign out_valid_o = tr_valid;
  assign world_x_o   = $signed(wx);
  assign world_y_o   = $signed(wy);
  assign world_z_o   = $signed(wz);

endmodule
